[hw/rtl/kcbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key chord tracker package
// Shared constants, codes and record types of the key chord tracker.
// ----------------------------------------------------------------------------
package kcbt_pkg;

  // Block dimensions.
  localparam int NUM_BINDINGS     = 8;
  localparam int KEYS_PER_BINDING = 4;
  localparam int KEY_CODE_BITS    = 7;

  // Fixed field widths of the channels.
  localparam int REQ_W     = 2;
  localparam int IN_KEY_W  = 7;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 31;

  // Binding register layout: codes from bit 0, then a 3-bit key count.
  localparam int COUNT_W   = 3;
  localparam int COUNT_LSB = KEYS_PER_BINDING * KEY_CODE_BITS;
  localparam int BIND_W    = COUNT_LSB + COUNT_W;

  typedef logic [KEY_CODE_BITS-1:0] key_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [BIND_W-1:0]        bind_t;
  typedef logic [MASK_W-1:0]        mask_t;

  // Request kinds. The fourth code is ignored by the block.
  typedef enum logic [REQ_W-1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2
  } req_t;

  // Binding phases.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_DOWN     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  // Event broadcast to every binding unit.
  typedef struct packed {
    logic valid;
    req_t kind;
    key_t key;
  } event_t;

  // Per-binding status for the current event.
  typedef struct packed {
    logic pressed;
    logic released;
    logic down;
  } bind_status_t;

  // One result record.
  typedef struct packed {
    mask_t pressed_mask;
    mask_t released_mask;
    mask_t down_mask;
    logic  any_key;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/kcbt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key event channel
// Valid/ready channel that carries one key event request.
// ----------------------------------------------------------------------------
interface kcbt_in_if;
  logic                          valid;
  logic                          ready;
  logic [kcbt_pkg::REQ_W-1:0]    req_type;
  logic [kcbt_pkg::IN_KEY_W-1:0] key_code;

  modport source (output valid, output req_type, output key_code, input ready);
  modport sink (input valid, input req_type, input key_code, output ready);
endinterface
`default_nettype wire

[hw/rtl/kcbt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chord result channel
// Valid/ready channel that carries the binding masks of one request.
// ----------------------------------------------------------------------------
interface kcbt_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcbt_pkg::MASK_W-1:0] pressed_mask;
  logic [kcbt_pkg::MASK_W-1:0] released_mask;
  logic [kcbt_pkg::MASK_W-1:0] down_mask;
  logic                        any_key_since_tick;

  modport source (output valid, output pressed_mask, output released_mask,
                  output down_mask, output any_key_since_tick, input ready);
  modport sink (input valid, input pressed_mask, input released_mask,
                input down_mask, input any_key_since_tick, output ready);
endinterface
`default_nettype wire

[hw/rtl/kcbt_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes one binding register.
// ----------------------------------------------------------------------------
interface kcbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kcbt_pkg::CFG_IDX_W-1:0] index;
  logic [kcbt_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/key_chord_binding_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result is registered into a two-entry result queue on acceptance,
// which lets requests flow while one result waits. Throughput: one request
// per cycle while the queue has room; all bindings are stepped in parallel.
// Reset (rst_n low, synchronous) clears all bindings, held flags, phases,
// the any-key flag and the result queue; configuration is always ready.
// ----------------------------------------------------------------------------
// Key chord binding tracker
// Tracks chord bindings over key press, release and frame tick requests.
// ----------------------------------------------------------------------------
module key_chord_binding_tracker_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kcbt_in_if.sink    in_ch,
  kcbt_out_if.source out_ch,
  kcbt_cfg_if.sink   cfg_ch
);

  logic                                in_accept;
  logic                                cfg_accept;
  logic                                can_push;
  kcbt_pkg::event_t                    ev;
  kcbt_pkg::bind_status_t              status [kcbt_pkg::NUM_BINDINGS];
  logic [kcbt_pkg::NUM_BINDINGS-1:0]   pressed_vec;
  logic [kcbt_pkg::NUM_BINDINGS-1:0]   released_vec;
  logic [kcbt_pkg::NUM_BINDINGS-1:0]   down_vec;
  logic                                any_key_r;
  logic                                any_key_nxt;
  kcbt_pkg::result_t                   result;
  kcbt_pkg::result_t                   head;

  // Handshakes.
  assign in_ch.ready  = can_push;
  assign in_accept    = in_ch.valid && can_push;
  assign cfg_ch.ready = 1'b1;
  assign cfg_accept   = cfg_ch.valid;

  // Request broadcast to the binding units.
  assign ev.valid = in_accept;
  assign ev.kind  = kcbt_pkg::req_t'(in_ch.req_type);
  assign ev.key   = kcbt_pkg::key_t'(in_ch.key_code);

  // One unit per binding.
  for (genvar b = 0; b < kcbt_pkg::NUM_BINDINGS; b++) begin : g_bind
    kcbt_binding_unit u_bind (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg_we  (cfg_accept && (cfg_ch.index == kcbt_pkg::CFG_IDX_W'(b))),
      .cfg_val (kcbt_pkg::bind_t'(cfg_ch.data)),
      .ev      (ev),
      .status  (status[b])
    );
    assign pressed_vec[b]  = status[b].pressed;
    assign released_vec[b] = status[b].released;
    assign down_vec[b]     = status[b].down;
  end

  // Any-key flag: set by a press, cleared by a tick.
  always_comb begin
    any_key_nxt = any_key_r;
    if (in_accept) begin
      case (ev.kind)
        kcbt_pkg::REQ_PRESS: any_key_nxt = 1'b1;
        kcbt_pkg::REQ_TICK:  any_key_nxt = 1'b0;
        default:             any_key_nxt = any_key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_key_r <= 1'b0;
    end else begin
      any_key_r <= any_key_nxt;
    end
  end

  // Result record for the accepted request.
  assign result.pressed_mask  = kcbt_pkg::mask_t'(pressed_vec);
  assign result.released_mask = kcbt_pkg::mask_t'(released_vec);
  assign result.down_mask     = kcbt_pkg::mask_t'(down_vec);
  assign result.any_key       = any_key_nxt;

  kcbt_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (result),
    .can_push   (can_push),
    .pop        (out_ch.ready),
    .head_valid (out_ch.valid),
    .head_data  (head)
  );

  assign out_ch.pressed_mask       = head.pressed_mask;
  assign out_ch.released_mask      = head.released_mask;
  assign out_ch.down_mask          = head.down_mask;
  assign out_ch.any_key_since_tick = head.any_key;

endmodule
`default_nettype wire

[hw/rtl/kcbt_binding_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binding unit
// Holds one chord binding, its held flags and its phase, and steps them on
// each accepted request.
// ----------------------------------------------------------------------------
module kcbt_binding_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire kcbt_pkg::bind_t        cfg_val,
  input  wire kcbt_pkg::event_t       ev,
  output kcbt_pkg::bind_status_t      status
);

  kcbt_pkg::bind_t                          bind_r;
  logic [kcbt_pkg::KEYS_PER_BINDING-1:0]    held_r;
  logic [kcbt_pkg::KEYS_PER_BINDING-1:0]    held_nxt;
  kcbt_pkg::phase_t                         phase_r;
  kcbt_pkg::phase_t                         phase_nxt;
  kcbt_pkg::count_t                         count_raw;
  kcbt_pkg::count_t                         count_sat;
  logic [kcbt_pkg::KEYS_PER_BINDING-1:0]    active;
  logic [kcbt_pkg::KEYS_PER_BINDING-1:0]    hit;
  logic                                     used;
  logic                                     all_held;
  logic                                     is_up;
  logic                                     is_down;

  // Key count, saturated to the number of slots.
  assign count_raw = bind_r[kcbt_pkg::COUNT_LSB +: kcbt_pkg::COUNT_W];
  always_comb begin
    if (count_raw > kcbt_pkg::count_t'(kcbt_pkg::KEYS_PER_BINDING)) begin
      count_sat = kcbt_pkg::count_t'(kcbt_pkg::KEYS_PER_BINDING);
    end else begin
      count_sat = count_raw;
    end
  end
  assign used = (count_sat != '0);

  // Slot compare against the request key; only slots below the count take part.
  always_comb begin
    for (int k = 0; k < kcbt_pkg::KEYS_PER_BINDING; k++) begin
      active[k] = (kcbt_pkg::count_t'(k) < count_sat);
      hit[k]    = active[k] &&
                  (bind_r[k*kcbt_pkg::KEY_CODE_BITS +: kcbt_pkg::KEY_CODE_BITS] == ev.key);
    end
  end

  assign is_up   = (phase_r == kcbt_pkg::PH_IDLE) || (phase_r == kcbt_pkg::PH_RELEASED);
  assign is_down = (phase_r == kcbt_pkg::PH_PRESSED) || (phase_r == kcbt_pkg::PH_DOWN);

  // Next held flags and next phase.
  always_comb begin
    held_nxt  = held_r;
    phase_nxt = phase_r;
    all_held  = 1'b0;
    if (ev.valid) begin
      case (ev.kind)
        kcbt_pkg::REQ_PRESS: begin
          held_nxt = held_r | hit;
          all_held = &(held_nxt | ~active);
          if (used && all_held && is_up) begin
            phase_nxt = kcbt_pkg::PH_PRESSED;
          end
        end
        kcbt_pkg::REQ_RELEASE: begin
          held_nxt = held_r & ~hit;
          all_held = &(held_nxt | ~active);
          if (used && !all_held && is_down) begin
            phase_nxt = kcbt_pkg::PH_RELEASED;
          end
        end
        kcbt_pkg::REQ_TICK: begin
          if (phase_r == kcbt_pkg::PH_PRESSED) begin
            phase_nxt = kcbt_pkg::PH_DOWN;
          end else if (phase_r == kcbt_pkg::PH_RELEASED) begin
            phase_nxt = kcbt_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status of this binding for the current request.
  always_comb begin
    status.pressed  = (phase_nxt == kcbt_pkg::PH_PRESSED) && (phase_r != kcbt_pkg::PH_PRESSED);
    status.released = (phase_nxt == kcbt_pkg::PH_RELEASED) &&
                      (phase_r != kcbt_pkg::PH_RELEASED);
    status.down     = (phase_nxt == kcbt_pkg::PH_PRESSED) || (phase_nxt == kcbt_pkg::PH_DOWN);
  end

  // A register write replaces the binding and restarts it from idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_r  <= '0;
      held_r  <= '0;
      phase_r <= kcbt_pkg::PH_IDLE;
    end else if (cfg_we) begin
      bind_r  <= cfg_val;
      held_r  <= '0;
      phase_r <= kcbt_pkg::PH_IDLE;
    end else begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/kcbt_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output queue so a new request is taken while a result waits.
// ----------------------------------------------------------------------------
module kcbt_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire kcbt_pkg::result_t push_data,
  output logic                   can_push,
  input  wire logic              pop,
  output logic                   head_valid,
  output kcbt_pkg::result_t      head_data
);

  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  kcbt_pkg::result_t head_r;
  kcbt_pkg::result_t tail_r;
  logic              do_pop;

  assign can_push   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = head_r;
  assign do_pop     = pop && head_valid;

  // Occupancy.
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry data: the tail moves up on a pop, a push fills the first free entry.
  always_ff @(posedge clk) begin
    if (do_pop && (count_r == 2'd2)) begin
      head_r <= tail_r;
    end
    if (push) begin
      if ((count_r == 2'd0) || ((count_r == 2'd1) && do_pop)) begin
        head_r <= push_data;
      end else begin
        tail_r <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/kcbt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key chord tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kcbt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [kcbt_pkg::MASK_W-1:0] pressed_mask,
  input wire logic [kcbt_pkg::MASK_W-1:0] released_mask,
  input wire logic [kcbt_pkg::MASK_W-1:0] down_mask,
  input wire logic                        any_key
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pressed_mask) &&
    $stable(released_mask) && $stable(down_mask) && $stable(any_key))
    else $error("stalled result changed");

  // A binding that was just pressed is down.
  a_pressed_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((pressed_mask & ~down_mask) == '0))
    else $error("pressed binding not reported down");

  // A binding that was just released is not down, and not also pressed.
  a_released_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((released_mask & down_mask) == '0) &&
    ((released_mask & pressed_mask) == '0))
    else $error("released binding reported down or pressed");

endmodule

bind key_chord_binding_tracker_top kcbt_checker u_kcbt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pressed_mask  (out_ch.pressed_mask),
  .released_mask (out_ch.released_mask),
  .down_mask     (out_ch.down_mask),
  .any_key       (out_ch.any_key_since_tick)
);
`default_nettype wire

[dv/tb_key_chord_binding_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key chord binding tracker testbench
// Streams key press, release and frame tick requests into the tracker.
// A shadow tracker predicts the pressed, released and down masks of every
// request, and a checker compares them with each result in order.
// Binding registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_key_chord_binding_tracker_top;
  import kcbt_pkg::*;

  // The fourth request code, which the block ignores.
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 6;

  logic clk;
  logic rst_n;

  kcbt_in_if  in_bus ();
  kcbt_out_if out_bus ();
  kcbt_cfg_if cfg_bus ();

  key_chord_binding_tracker_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // Shadow copy of the binding registers, held flags, phases and any-key flag.
  bind_t   chord_reg   [NUM_BINDINGS];
  logic    key_held    [NUM_BINDINGS][KEYS_PER_BINDING];
  phase_t  chord_phase [NUM_BINDINGS];
  logic    key_seen;

  // Masks still owed by the block, oldest first.
  result_t masks_due [$];

  // Register values staged for the next configuration pass.
  bind_t   chord_plan  [NUM_BINDINGS];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned events_sent  = 0;
  int unsigned burst_left   = 0;
  bit          tx_idle_on   = 1'b0;
  bit          rx_stall_on  = 1'b0;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Number of live slots of a binding, with the count saturated.
  function automatic int unsigned keys_in_chord(int b);
    count_t c;
    c = chord_reg[b][COUNT_LSB +: COUNT_W];
    if (c > KEYS_PER_BINDING) return KEYS_PER_BINDING;
    return c;
  endfunction

  function automatic key_t chord_key(int b, int k);
    return chord_reg[b][k*KEY_CODE_BITS +: KEY_CODE_BITS];
  endfunction

  function automatic bind_t pack_chord(int cnt, key_t k0, key_t k1, key_t k2, key_t k3);
    return {count_t'(cnt), k3, k2, k1, k0};
  endfunction

  // Advances the shadow tracker by one request and returns its masks.
  function automatic result_t step_chord_model(logic [REQ_W-1:0] kind, key_t code);
    result_t     r;
    int unsigned n;
    int unsigned held;
    logic        press;
    r = '0;
    if (kind == REQ_PRESS || kind == REQ_RELEASE) begin
      press = (kind == REQ_PRESS);
      if (press) key_seen = 1'b1;
      for (int b = 0; b < NUM_BINDINGS; b++) begin
        n    = keys_in_chord(b);
        held = 0;
        for (int k = 0; k < n; k++) begin
          if (chord_key(b, k) == code) key_held[b][k] = press;
          if (key_held[b][k]) held++;
        end
        // An unused binding never changes phase.
        if (n != 0) begin
          if (press && held == n &&
              (chord_phase[b] == PH_IDLE || chord_phase[b] == PH_RELEASED)) begin
            chord_phase[b]     = PH_PRESSED;
            r.pressed_mask[b]  = 1'b1;
          end
          if (!press && held < n &&
              (chord_phase[b] == PH_PRESSED || chord_phase[b] == PH_DOWN)) begin
            chord_phase[b]     = PH_RELEASED;
            r.released_mask[b] = 1'b1;
          end
        end
      end
    end else if (kind == REQ_TICK) begin
      key_seen = 1'b0;
      for (int b = 0; b < NUM_BINDINGS; b++) begin
        if (chord_phase[b] == PH_PRESSED) chord_phase[b] = PH_DOWN;
        else if (chord_phase[b] == PH_RELEASED) chord_phase[b] = PH_IDLE;
      end
    end
    for (int b = 0; b < NUM_BINDINGS; b++)
      r.down_mask[b] = (chord_phase[b] == PH_PRESSED || chord_phase[b] == PH_DOWN);
    r.any_key = key_seen;
    return r;
  endfunction

  // Sends one key request and records its expected masks. In idling mode the
  // sender works in bursts and drops valid for a random gap after each burst.
  task automatic post_key_event(logic [REQ_W-1:0] kind, key_t code);
    int unsigned gap;
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.key_code <= code;
    do @(posedge clk); while (!in_bus.ready);
    masks_due.insert(masks_due.size(), step_chord_model(kind, code));
    events_sent++;
    if (tx_idle_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops requests and waits until every owed result has come back.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (masks_due.size() != 0) @(posedge clk);
  endtask

  // Writes the staged values to the selected binding registers.
  task automatic load_chords(logic [NUM_BINDINGS-1:0] which);
    for (int b = 0; b < NUM_BINDINGS; b++) begin
      if (which[b]) begin
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_IDX_W'(b);
        cfg_bus.data  <= chord_plan[b];
        do @(posedge clk); while (!cfg_bus.ready);
        chord_reg[b]   = chord_plan[b];
        chord_phase[b] = PH_IDLE;
        for (int k = 0; k < KEYS_PER_BINDING; k++) key_held[b][k] = 1'b0;
      end
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Result receiver: always ready, or alternating ready runs and stalls.
  initial begin : result_sink
    int unsigned run;
    bit          stall;
    run   = 0;
    stall = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rx_stall_on) begin
        out_bus.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          stall = !stall;
          run   = stall ? $urandom_range(1, 7) : $urandom_range(1, 14);
        end else begin
          run--;
        end
        out_bus.ready <= !stall;
      end
    end
  end

  // Compares each accepted result with the oldest expected masks.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.pressed_mask  = out_bus.pressed_mask;
      got.released_mask = out_bus.released_mask;
      got.down_mask     = out_bus.down_mask;
      got.any_key       = out_bus.any_key_since_tick;
      if (masks_due.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result: pressed %h released %h down %h any %b",
                   got.pressed_mask, got.released_mask, got.down_mask, got.any_key);
        mismatch_cnt++;
      end else begin
        want = masks_due.pop_front();
        if (got.pressed_mask !== want.pressed_mask ||
            got.released_mask !== want.released_mask ||
            got.down_mask !== want.down_mask ||
            got.any_key !== want.any_key) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display({"mask mismatch (expected/actual): pressed %h/%h released %h/%h",
                      " down %h/%h any %b/%b"},
                     want.pressed_mask, got.pressed_mask,
                     want.released_mask, got.released_mask,
                     want.down_mask, got.down_mask, want.any_key, got.any_key);
          mismatch_cnt++;
        end
      end
    end
  end

  // Right after reset every binding is unused, so no request moves a mask.
  task automatic test_reset_defaults();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    post_key_event(REQ_TICK, 7'd0);
    post_key_event(REQ_IGNORED, 7'd127);
    post_key_event(REQ_PRESS, 7'd127);
    post_key_event(REQ_RELEASE, 7'd0);
    drain_results();
  endtask

  // Hand-picked bindings and requests for the corner cases.
  task automatic test_directed_chords();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    // Two-key chord whose upper slots hold codes that must never match.
    chord_plan[0] = pack_chord(2, 7'd0, 7'd127, 7'd5, 7'd9);
    // Duplicate code in two slots.
    chord_plan[1] = pack_chord(4, 7'd10, 7'd10, 7'd20, 7'd30);
    // Count above the slot limit saturates.
    chord_plan[2] = pack_chord(7, 7'd1, 7'd2, 7'd3, 7'd4);
    chord_plan[3] = pack_chord(1, 7'd127, 7'd0, 7'd0, 7'd0);
    // Zero count: unused even though its codes match.
    chord_plan[4] = pack_chord(0, 7'd0, 7'd127, 7'd0, 7'd0);
    chord_plan[5] = '1;
    chord_plan[6] = '0;
    chord_plan[7] = pack_chord(3, 7'd40, 7'd41, 7'd42, 7'd5);
    load_chords('1);

    post_key_event(REQ_PRESS, 7'd0);
    post_key_event(REQ_PRESS, 7'd127);
    // Press on bindings that are already down.
    post_key_event(REQ_PRESS, 7'd127);
    post_key_event(REQ_TICK, 7'd85);
    // Code of a slot beyond the count.
    post_key_event(REQ_PRESS, 7'd5);
    post_key_event(REQ_RELEASE, 7'd0);
    // Release on a binding that is already up.
    post_key_event(REQ_RELEASE, 7'd0);
    post_key_event(REQ_TICK, 7'd42);
    post_key_event(REQ_PRESS, 7'd0);
    post_key_event(REQ_PRESS, 7'd10);
    post_key_event(REQ_PRESS, 7'd20);
    post_key_event(REQ_PRESS, 7'd30);
    // Releasing a duplicated code clears both slots.
    post_key_event(REQ_RELEASE, 7'd10);
    // Pressed again before the tick: RELEASED goes straight to PRESSED.
    post_key_event(REQ_PRESS, 7'd10);
    post_key_event(REQ_IGNORED, 7'd127);
    post_key_event(REQ_PRESS, 7'd1);
    post_key_event(REQ_PRESS, 7'd2);
    post_key_event(REQ_PRESS, 7'd3);
    post_key_event(REQ_PRESS, 7'd4);
    post_key_event(REQ_RELEASE, 7'd127);
    post_key_event(REQ_TICK, 7'd0);
    post_key_event(REQ_TICK, 7'd127);
    post_key_event(REQ_RELEASE, 7'd40);
    drain_results();
  endtask

  // Random bindings per phase; mostly full chord strokes with random timing,
  // the rest noise on the same key pool and fully random requests.
  task automatic test_random_chords();
    key_t        pool [POOL_SIZE];
    key_t        keys [KEYS_PER_BINDING];
    key_t        swap_key;
    int unsigned goal;
    int unsigned phase_end;
    int unsigned n;
    int unsigned pick;
    int unsigned r;
    int unsigned j;
    int          b;
    int          phase;
    bit          rev;
    goal  = events_sent + RANDOM_ITEMS;
    phase = 0;
    while (events_sent < goal) begin
      drain_results();

      // New key pool and bindings built mostly from it.
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = key_t'($urandom_range(0, 127));
      for (int i = 0; i < NUM_BINDINGS; i++) begin
        for (int k = 0; k < KEYS_PER_BINDING; k++)
          keys[k] = ($urandom_range(0, 7) == 0) ? key_t'($urandom_range(0, 127))
                                                : pool[$urandom_range(0, POOL_SIZE-1)];
        r = $urandom_range(0, 15);
        n = (r == 0) ? 0 : (r <= 12) ? 1 + r % 4 : 5 + r % 3;
        chord_plan[i] = pack_chord(n, keys[0], keys[1], keys[2], keys[3]);
        if ($urandom_range(0, 31) == 0) chord_plan[i] = '1;
      end
      load_chords((phase == 0) ? '1 : NUM_BINDINGS'($urandom_range(1, 255)));

      case (phase % 4)
        0: begin tx_idle_on = 1'b1; rx_stall_on = 1'b1; end
        1: begin tx_idle_on = 1'b0; rx_stall_on = 1'b0; end
        2: begin tx_idle_on = 1'b1; rx_stall_on = 1'b0; end
        default: begin tx_idle_on = 1'b0; rx_stall_on = 1'b1; end
      endcase

      phase_end = events_sent + $urandom_range(150, 250);
      while (events_sent < phase_end && events_sent < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // Full stroke of one binding: press all keys, then release them.
          b = $urandom_range(0, NUM_BINDINGS-1);
          n = keys_in_chord(b);
          for (int k = 0; k < n; k++) keys[k] = chord_key(b, k);
          for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            swap_key = keys[k];
            keys[k]  = keys[j];
            keys[j]  = swap_key;
          end
          for (int k = 0; k < n; k++) begin
            post_key_event(REQ_PRESS, keys[k]);
            if ($urandom_range(0, 4) == 0) post_key_event(REQ_TICK, key_t'($urandom));
          end
          if (n > 0 && $urandom_range(0, 3) == 0) begin
            post_key_event(REQ_RELEASE, keys[0]);
            post_key_event(REQ_PRESS, keys[0]);
          end
          if ($urandom_range(0, 1) == 1) post_key_event(REQ_TICK, key_t'($urandom));
          rev = $urandom_range(0, 1);
          for (int k = 0; k < n; k++) begin
            post_key_event(REQ_RELEASE, keys[rev ? n - 1 - k : k]);
            if ($urandom_range(0, 4) == 0) post_key_event(REQ_TICK, key_t'($urandom));
          end
          if ($urandom_range(0, 1) == 1) post_key_event(REQ_TICK, key_t'($urandom));
        end else if (pick < 9) begin
          // Noise on the phase's key pool, every request kind included.
          post_key_event(REQ_W'($urandom_range(0, 3)), pool[$urandom_range(0, POOL_SIZE-1)]);
        end else begin
          post_key_event(REQ_W'($urandom_range(0, 3)), key_t'($urandom_range(0, 127)));
        end
      end
      phase++;
    end
  endtask

  // Main sequence.
  initial begin
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= REQ_PRESS;
    in_bus.key_code <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= '0;
    cfg_bus.data    <= '0;
    key_seen = 1'b0;
    for (int b = 0; b < NUM_BINDINGS; b++) begin
      chord_reg[b]   = '0;
      chord_phase[b] = PH_IDLE;
      for (int k = 0; k < KEYS_PER_BINDING; k++) key_held[b][k] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_chords();
    test_random_chords();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && masks_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hw/rtl/kcbt_pkg.sv
hw/rtl/kcbt_in_if.sv
hw/rtl/kcbt_out_if.sv
hw/rtl/kcbt_cfg_if.sv
hw/rtl/kcbt_binding_unit.sv
hw/rtl/kcbt_out_buf.sv
hw/rtl/key_chord_binding_tracker_top.sv
hw/rtl/kcbt_checker.sv
dv/tb_key_chord_binding_tracker_top.sv
